### rtl/core/hexl_pkg.sv
package hexl_pkg;

   // Field widths of the request and result items.
   localparam int COORD_BITS = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int CELL_BITS  = 12;

   // Fixed-point format of the fractional axial coordinates.
   localparam int FRAC_BITS  = 16;
   localparam int WORK_BITS  = 28;
   localparam int PRE_SHIFT  = WORK_BITS - FRAC_BITS;

   // Numerator before and after the power-of-two part of the divisor is removed.
   localparam int NUMER_W    = 48;
   localparam int SNUM_W     = NUMER_W - PRE_SHIFT;
   localparam int DIV_W      = SNUM_W - 1;

   // Divisor is three times the cell size.
   localparam int SIZE_W     = 10;
   localparam int DVSR_W     = SIZE_W + 2;

   // Rounded coordinates and their rounding errors.
   localparam int QX_W       = SNUM_W + 1;
   localparam int RND_W      = QX_W - FRAC_BITS + 1;
   localparam int ERR_W      = FRAC_BITS + 1;

   // Configuration register widths.
   localparam int COUNT_W    = 11;
   localparam int RADIUS_W   = 9;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   // sqrt(3) in Q28, which is three times sqrt(3)/3.
   localparam logic signed [30:0] SQRT3_Q28 = 31'sd464943849;

   typedef enum logic [2:0] {
      LAYOUT_ODD_Q   = 3'd0,
      LAYOUT_EVEN_Q  = 3'd1,
      LAYOUT_ODD_R   = 3'd2,
      LAYOUT_EVEN_R  = 3'd3,
      LAYOUT_HEXAGON = 3'd4
   } layout_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LAYOUT  = 3'd0,
      CSR_CENTER_X = 3'd1,
      CSR_CENTER_Y = 3'd2,
      CSR_SIZE    = 3'd3,
      CSR_COLUMNS = 3'd4,
      CSR_ROWS    = 3'd5,
      CSR_RADIUS  = 3'd6
   } csr_addr_type;

   // One division lane: partial remainder and the dividend/quotient word.
   typedef struct packed {
      logic [DVSR_W-1:0] rem;
      logic [DIV_W-1:0]  work;
   } div_lane_type;

   // What travels from one divider cell to the next.
   typedef struct packed {
      logic         valid;
      logic         neg_x;
      logic         neg_z;
      div_lane_type lane_x;
      div_lane_type lane_z;
   } div_stage_type;

   typedef struct packed {
      logic signed [RND_W-1:0] val;
      logic [ERR_W-1:0]        err;
   } rnd_type;

   // Round half away from zero and return the absolute rounding error.
   function automatic rnd_type round_err(input logic signed [QX_W-1:0] v);
      logic                    neg;
      logic [QX_W-1:0]         mag;
      logic [QX_W-1:0]         sum;
      logic signed [RND_W-1:0] rmag;
      logic [FRAC_BITS-1:0]    frac;
      rnd_type                 res;
      neg  = v[QX_W-1];
      mag  = neg ? QX_W'(-v) : QX_W'(v);
      sum  = mag + (QX_W'(1) << (FRAC_BITS - 1));
      rmag = RND_W'({1'b0, sum[QX_W-1:FRAC_BITS]});
      frac = mag[FRAC_BITS-1:0];
      res.val = neg ? -rmag : rmag;
      res.err = frac[FRAC_BITS-1] ? ((ERR_W'(1) << FRAC_BITS) - ERR_W'(frac))
                                  : ERR_W'(frac);
      return res;
   endfunction

endpackage

### rtl/core/hexl_front.sv
module hexl_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic signed [hexl_pkg::COORD_BITS-1:0] pixel_x,
   input  logic signed [hexl_pkg::COORD_BITS-1:0] pixel_y,
   input  logic signed [hexl_pkg::COORD_BITS-1:0] center_x,
   input  logic signed [hexl_pkg::COORD_BITS-1:0] center_y,
   input  logic                                flat_top,
   output hexl_pkg::div_stage_type             div_out
);
   import hexl_pkg::*;

   logic                          v1_ff, v2_ff, v3_ff;
   logic signed [DIFF_BITS-1:0]   dx1_ff, dy1_ff, dx2_ff, dy2_ff;
   logic signed [NUMER_W-1:0]     prod2_ff;
   logic signed [NUMER_W-1:0]     prod_in;
   logic signed [DIFF_BITS-1:0]   msel;
   logic signed [NUMER_W-1:0]     dxw, dyw, xn, zn;
   logic signed [SNUM_W-1:0]      xs, zs;
   logic                          nx3_ff, nz3_ff;
   logic [DIV_W-1:0]              mx3_ff, mz3_ff;

   // Offsets from the map origin.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
      if (adv) begin
         dx1_ff <= DIFF_BITS'(pixel_x) - DIFF_BITS'(center_x);
         dy1_ff <= DIFF_BITS'(pixel_y) - DIFF_BITS'(center_y);
      end
   end

   // The sqrt(3) term uses dy for flat-top layouts and dx for pointy-top.
   assign msel    = flat_top ? dy1_ff : dx1_ff;
   assign prod_in = NUMER_W'(msel * SQRT3_Q28);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         prod2_ff <= prod_in;
         dx2_ff   <= dx1_ff;
         dy2_ff   <= dy1_ff;
      end
   end

   // Numerators in Q28 scaled by three; the 2^12 part of the divisor is a
   // floor shift, which leaves only 3*size for the divider chain.
   assign dxw = NUMER_W'(dx2_ff);
   assign dyw = NUMER_W'(dy2_ff);
   always_comb begin
      if (flat_top) begin
         xn = dxw <<< (WORK_BITS + 1);
         zn = prod2_ff - (dxw <<< WORK_BITS);
      end else begin
         xn = prod2_ff - (dyw <<< WORK_BITS);
         zn = dyw <<< (WORK_BITS + 1);
      end
   end
   assign xs = xn[NUMER_W-1:PRE_SHIFT];
   assign zs = zn[NUMER_W-1:PRE_SHIFT];

   // Floor division of a negative value divides its complement and
   // complements the quotient.
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         nx3_ff <= xs[SNUM_W-1];
         nz3_ff <= zs[SNUM_W-1];
         mx3_ff <= xs[SNUM_W-1] ? ~xs[DIV_W-1:0] : xs[DIV_W-1:0];
         mz3_ff <= zs[SNUM_W-1] ? ~zs[DIV_W-1:0] : zs[DIV_W-1:0];
      end
   end

   always_comb begin
      div_out.valid       = v3_ff;
      div_out.neg_x       = nx3_ff;
      div_out.neg_z       = nz3_ff;
      div_out.lane_x.rem  = '0;
      div_out.lane_x.work = mx3_ff;
      div_out.lane_z.rem  = '0;
      div_out.lane_z.work = mz3_ff;
   end

endmodule

### rtl/core/hexl_div_cell.sv
module hexl_div_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [hexl_pkg::DVSR_W-1:0]   divisor,
   input  hexl_pkg::div_stage_type       prev,
   output hexl_pkg::div_stage_type       next
);
   import hexl_pkg::*;

   div_stage_type stage_ff, stage_in;

   // One restoring step: bring down the next dividend bit, subtract if it fits.
   function automatic div_lane_type step(input div_lane_type l,
                                         input logic [DVSR_W-1:0] d);
      logic [DVSR_W:0] t;
      logic            ge;
      div_lane_type    o;
      t  = {l.rem, l.work[DIV_W-1]};
      ge = t >= {1'b0, d};
      o.rem  = ge ? DVSR_W'(t - {1'b0, d}) : t[DVSR_W-1:0];
      o.work = {l.work[DIV_W-2:0], ge};
      return o;
   endfunction

   always_comb begin
      stage_in        = prev;
      stage_in.lane_x = step(prev.lane_x, divisor);
      stage_in.lane_z = step(prev.lane_z, divisor);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (adv) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (adv) begin
         stage_ff.neg_x  <= stage_in.neg_x;
         stage_ff.neg_z  <= stage_in.neg_z;
         stage_ff.lane_x <= stage_in.lane_x;
         stage_ff.lane_z <= stage_in.lane_z;
      end
   end

   assign next = stage_ff;

endmodule

### rtl/core/hexl_back.sv
module hexl_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  hexl_pkg::div_stage_type             div_in,
   input  hexl_pkg::layout_type                layout,
   input  logic [hexl_pkg::COUNT_W-1:0]        columns,
   input  logic [hexl_pkg::COUNT_W-1:0]        rows,
   input  logic [hexl_pkg::RADIUS_W-1:0]       ring_radius,
   output logic                                out_valid,
   output logic signed [hexl_pkg::CELL_BITS-1:0] cell_q,
   output logic signed [hexl_pkg::CELL_BITS-1:0] cell_r,
   output logic                                in_map
);
   import hexl_pkg::*;

   localparam int BW = RND_W + 2;

   logic signed [QX_W-1:0]  qx, qz, qy;
   rnd_type                 rx_in, ry_in, rz_in;
   rnd_type                 rx_ff, ry_ff, rz_ff;
   logic                    v4_ff, v5_ff;
   logic signed [RND_W-1:0] cq_in, cr_in, cq_ff, cr_ff;

   // Quotients back to signed Q16; y is the third cube coordinate.
   assign qx = QX_W'($signed({div_in.neg_x,
                  div_in.neg_x ? ~div_in.lane_x.work : div_in.lane_x.work}));
   assign qz = QX_W'($signed({div_in.neg_z,
                  div_in.neg_z ? ~div_in.lane_z.work : div_in.lane_z.work}));
   assign qy = -qx - qz;
   assign rx_in = round_err(qx);
   assign ry_in = round_err(qy);
   assign rz_in = round_err(qz);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= div_in.valid;
      end
      if (adv) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         rz_ff <= rz_in;
      end
   end

   // Rebuild the component with the largest rounding error.
   always_comb begin
      cq_in = rx_ff.val;
      cr_in = rz_ff.val;
      if (rx_ff.err > ry_ff.err && rx_ff.err > rz_ff.err) begin
         cq_in = -ry_ff.val - rz_ff.val;
      end else if (!(ry_ff.err > rz_ff.err)) begin
         cr_in = -rx_ff.val - ry_ff.val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
      if (adv) begin
         cq_ff <= cq_in;
         cr_ff <= cr_in;
      end
   end

   // Map bounds check.
   logic signed [BW-1:0] q, r, major, minor, shift_up, kk, sum_qr;
   logic signed [BW-1:0] n_major, n_minor, rad;
   logic                 odd_kind, offset_ok;

   always_comb begin
      q       = BW'(cq_ff);
      r       = BW'(cr_ff);
      rad     = BW'($signed({1'b0, ring_radius}));
      sum_qr  = q + r;
      if (layout == LAYOUT_ODD_Q || layout == LAYOUT_EVEN_Q) begin
         major   = q;
         minor   = r;
         n_major = BW'($signed({1'b0, columns}));
         n_minor = BW'($signed({1'b0, rows}));
      end else begin
         major   = r;
         minor   = q;
         n_major = BW'($signed({1'b0, rows}));
         n_minor = BW'($signed({1'b0, columns}));
      end
      odd_kind  = (layout == LAYOUT_ODD_Q || layout == LAYOUT_ODD_R);
      shift_up  = odd_kind ? (major >>> 1) : ((major + BW'(1)) >>> 1);
      kk        = minor + shift_up;
      offset_ok = major >= 0 && major < n_major && kk >= 0 && kk < n_minor;
      unique case (layout)
         LAYOUT_ODD_Q, LAYOUT_EVEN_Q, LAYOUT_ODD_R, LAYOUT_EVEN_R: begin
            in_map = offset_ok;
         end
         LAYOUT_HEXAGON: begin
            in_map = sum_qr <= rad && sum_qr >= -rad && q <= rad && q >= -rad
                     && r <= rad && r >= -rad;
         end
         default: begin
            in_map = 1'b0;
         end
      endcase
   end

   assign out_valid = v5_ff;
   assign cell_q    = in_map ? cq_ff[CELL_BITS-1:0] : '0;
   assign cell_r    = in_map ? cr_ff[CELL_BITS-1:0] : '0;

endmodule

### rtl/core/pixel_to_hex_cell_locator_core.sv
// Channel   Direction  Handshake           Contents
// req_      in         tvalid / tready     tdata: pixel_x, pixel_y
// rsp_      out        tvalid / tready     tdata: cell_q, cell_r; tuser: inside_res
// csr_      in         we (no wait)        addr, wdata
//
// One request per cycle is accepted while the pipeline advances; each result passes
// through hexl_front, the one-bit divider cells (one quotient bit per cell) and hexl_back.
// Reset is synchronous; it restores the configuration registers to their
// documented values and clears every valid flag.
// When a result waits at the output, the pipeline keeps moving as long as its
// last stage is empty; it halts as a whole only when that stage is full too.
module pixel_to_hex_cell_locator_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,   // pixel_x, pixel_y
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [23:0]                        rsp_tdata,   // cell_q, cell_r
   output logic                               rsp_tuser,   // inside_res
   input  logic                               csr_we,
   input  logic [hexl_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [hexl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hexl_pkg::*;

   logic [2:0]                  layout_ff;
   logic signed [COORD_BITS-1:0] center_x_ff, center_y_ff;
   logic [SIZE_W-1:0]           size_ff;
   logic [COUNT_W-1:0]          columns_ff, rows_ff;
   logic [RADIUS_W-1:0]         radius_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff   <= LAYOUT_ODD_Q;
         center_x_ff <= '0;
         center_y_ff <= '0;
         size_ff     <= SIZE_W'(32);
         columns_ff  <= COUNT_W'(16);
         rows_ff     <= COUNT_W'(16);
         radius_ff   <= RADIUS_W'(8);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_LAYOUT:   layout_ff   <= csr_wdata[2:0];
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            CSR_SIZE:     size_ff     <= csr_wdata[SIZE_W-1:0];
            CSR_COLUMNS:  columns_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_ROWS:     rows_ff     <= csr_wdata[COUNT_W-1:0];
            CSR_RADIUS:   radius_ff   <= csr_wdata[RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   // Divisor 3*size, where a zero size acts as one.
   logic [DVSR_W-1:0] size_eff, divisor;
   assign size_eff = (size_ff == '0) ? DVSR_W'(1) : DVSR_W'(size_ff);
   assign divisor  = size_eff + (size_eff << 1);

   logic flat_top;
   assign flat_top = (layout_ff == LAYOUT_ODD_Q || layout_ff == LAYOUT_EVEN_Q);

   // Pipeline advance.
   logic adv, last_valid;
   logic rsp_tvalid_ff;
   assign adv        = !(last_valid && rsp_tvalid_ff && !rsp_tready);
   assign req_tready = adv;

   div_stage_type chain [DIV_W+1];

   hexl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_tvalid),
      .pixel_x  (req_tdata[15:0]),
      .pixel_y  (req_tdata[31:16]),
      .center_x (center_x_ff),
      .center_y (center_y_ff),
      .flat_top (flat_top),
      .div_out  (chain[0])
   );

   // Divider chain: one quotient bit for both lanes per cell.
   for (genvar i = 0; i < DIV_W; i++) begin : g_cell
      hexl_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .divisor (divisor),
         .prev    (chain[i]),
         .next    (chain[i+1])
      );
   end

   logic signed [CELL_BITS-1:0] cq, cr;
   logic                        in_map;

   hexl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .div_in      (chain[DIV_W]),
      .layout      (layout_type'(layout_ff)),
      .columns     (columns_ff),
      .rows        (rows_ff),
      .ring_radius (radius_ff),
      .out_valid   (last_valid),
      .cell_q      (cq),
      .cell_r      (cr),
      .in_map      (in_map)
   );

   // Output register.
   logic [23:0] data_ff;
   logic        user_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv && last_valid) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
      if (adv && last_valid) begin
         data_ff <= {cr, cq};
         user_ff <= in_map;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

endmodule

### sim/tb_pixel_to_hex_cell_locator_core.sv
module tb_pixel_to_hex_cell_locator_core;
   import hexl_pkg::*;

   localparam int LATENCY = 42;
   localparam longint SQRT3_THIRD_Q28 = 154981283;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   typedef struct packed {
      logic signed [11:0] q;
      logic signed [11:0] r;
      logic               on_map;
   } cell_result;

   typedef struct {
      logic [15:0] px;
      logic [15:0] py;
      bit          known;
      cell_result  res;
   } directed_row;

   // Local copy of the configuration registers.
   logic [2:0]         layout_reg;
   logic signed [15:0] cx_reg;
   logic signed [15:0] cy_reg;
   logic [9:0]         size_reg;
   logic [10:0]        cols_reg;
   logic [10:0]        rows_reg;
   logic [8:0]         radius_reg;

   cell_result expected_cells[$];
   int  mismatches;
   bit  failed;
   int  received;

   pixel_to_hex_cell_locator_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Generous overall limit.
   initial begin
      #(20 * 2000000);
      $display("== FAIL ==");
      $finish;
   end

   function automatic longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint round_half_away(longint v);
      if (v >= 0) return (v + 32768) >>> 16;
      return -((-v + 32768) >>> 16);
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic bit in_offset_map(longint major, longint minor, longint nmajor,
                                        longint nminor, bit odd);
      longint first;
      if (major < 0 || major >= nmajor) return 0;
      first = odd ? -(major >>> 1) : -((major + 1) >>> 1);
      return (minor - first) >= 0 && (minor - first) < nminor;
   endfunction

   // Pixel to axial cell with cube rounding and the bounds check.
   function automatic cell_result locate_cell(logic [15:0] px, logic [15:0] py);
      longint dx, dy, s, den, fx, fy, fz, rx, ry, rz, ex, ey, ez, m;
      cell_result res;
      bit on_map;
      dx = longint'($signed(px)) - longint'(cx_reg);
      dy = longint'($signed(py)) - longint'(cy_reg);
      s = (size_reg == 0) ? 1 : longint'(size_reg);
      den = 3 * s * (longint'(1) << 12);
      on_map = 0;
      rx = 0;
      rz = 0;
      if (layout_reg <= LAYOUT_HEXAGON) begin
         if (layout_reg <= LAYOUT_EVEN_Q) begin
            fx = floor_quot(2 * dx * (longint'(1) << 28), den);
            fz = floor_quot(3 * SQRT3_THIRD_Q28 * dy - dx * (longint'(1) << 28), den);
         end else begin
            fx = floor_quot(3 * SQRT3_THIRD_Q28 * dx - dy * (longint'(1) << 28), den);
            fz = floor_quot(2 * dy * (longint'(1) << 28), den);
         end
         fy = -fx - fz;
         rx = round_half_away(fx);
         ry = round_half_away(fy);
         rz = round_half_away(fz);
         ex = mag(rx * 65536 - fx);
         ey = mag(ry * 65536 - fy);
         ez = mag(rz * 65536 - fz);
         if (ex > ey && ex > ez) rx = -ry - rz;
         else if (ey > ez) ry = -rx - rz;
         else rz = -rx - ry;
         if (layout_reg <= LAYOUT_EVEN_Q) begin
            on_map = in_offset_map(rx, rz, cols_reg, rows_reg, layout_reg == LAYOUT_ODD_Q);
         end else if (layout_reg <= LAYOUT_EVEN_R) begin
            on_map = in_offset_map(rz, rx, rows_reg, cols_reg, layout_reg == LAYOUT_ODD_R);
         end else begin
            m = mag(rx) > mag(rz) ? mag(rx) : mag(rz);
            on_map = mag(rx + rz) <= radius_reg && m <= radius_reg;
         end
      end
      res.q = on_map ? 12'(rx) : '0;
      res.r = on_map ? 12'(rz) : '0;
      res.on_map = on_map;
      return res;
   endfunction

   // Result checker and randomly stalling receiver.
   initial begin
      cell_result got;
      cell_result want;
      rsp_tready = 1'b0;
      mismatches = 0;
      failed = 0;
      received = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.q = rsp_tdata[11:0];
            got.r = rsp_tdata[23:12];
            got.on_map = rsp_tuser;
            received++;
            if (expected_cells.size() == 0) begin
               failed = 1;
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result q=%0d r=%0d inside=%0b",
                                              got.q, got.r, got.on_map);
            end else begin
               want = expected_cells.pop_front();
               if (got !== want) begin
                  failed = 1;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected q=%0d r=%0d inside=%0b, got q=%0d r=%0d inside=%0b",
                              want.q, want.r, want.on_map, got.q, got.r, got.on_map);
               end
            end
         end
         @(negedge clock);
         if ($urandom_range(0, 99) < 70) rsp_tready <= 1'b1;
         else if ($urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(5, 40)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else rsp_tready <= 1'b0;
      end
   end

   task automatic write_reg(csr_addr_type idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_LAYOUT:   layout_reg = val[2:0];
         CSR_CENTER_X: cx_reg = val;
         CSR_CENTER_Y: cy_reg = val;
         CSR_SIZE:     size_reg = val[9:0];
         CSR_COLUMNS:  cols_reg = val[10:0];
         CSR_ROWS:     rows_reg = val[10:0];
         CSR_RADIUS:   radius_reg = val[8:0];
         default: ;
      endcase
   endtask

   // Send one request, predicting its result when it is accepted.
   task automatic send_request(logic [15:0] px, logic [15:0] py, bit known, cell_result res);
      cell_result pred;
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         if ($urandom_range(0, 15) == 0) repeat ($urandom_range(10, 60)) @(negedge clock);
         else repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = locate_cell(px, py);
      if (known && pred !== res) begin
         failed = 1;
         $display("Predictor disagrees with table for x=%0d y=%0d", $signed(px), $signed(py));
      end
      expected_cells.push_back(pred);
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      req_tvalid <= 1'b0;
      guard = 0;
      while (expected_cells.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic random_config();
      int pick;
      pick = $urandom_range(0, 9);
      write_reg(CSR_LAYOUT, pick == 0 ? 16'($urandom_range(5, 7)) : 16'($urandom_range(0, 4)));
      write_reg(CSR_CENTER_X, $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2000) - 1000));
      write_reg(CSR_CENTER_Y, $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2000) - 1000));
      case ($urandom_range(0, 4))
         0: write_reg(CSR_SIZE, 16'(0));
         1: write_reg(CSR_SIZE, 16'(1023));
         default: write_reg(CSR_SIZE, 16'($urandom_range(1, 64)));
      endcase
      write_reg(CSR_COLUMNS, pick == 1 ? 16'(0) : ($urandom_range(0, 4) == 0 ? 16'(2047) : 16'($urandom_range(1, 40))));
      write_reg(CSR_ROWS, pick == 2 ? 16'(0) : ($urandom_range(0, 4) == 0 ? 16'(2047) : 16'($urandom_range(1, 40))));
      write_reg(CSR_RADIUS, $urandom_range(0, 4) == 0 ? 16'(511) : 16'($urandom_range(0, 30)));
   endtask

   initial begin
      directed_row rows_tbl[$];
      directed_row row;
      cell_result none;
      int spread;
      none = '0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = CSR_LAYOUT;
      csr_wdata = '0;
      layout_reg = LAYOUT_ODD_Q;
      cx_reg = 0;
      cy_reg = 0;
      size_reg = 32;
      cols_reg = 16;
      rows_reg = 16;
      radius_reg = 8;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part with reset settings: origin, corners of the field range.
      rows_tbl.push_back('{16'd0, 16'd0, 1, '{12'd0, 12'd0, 1'b1}});
      rows_tbl.push_back('{16'h8000, 16'h8000, 1, none});
      rows_tbl.push_back('{16'h7FFF, 16'h7FFF, 1, none});
      rows_tbl.push_back('{16'h8000, 16'h7FFF, 1, none});
      rows_tbl.push_back('{16'h7FFF, 16'h8000, 1, none});
      rows_tbl.push_back('{16'd48, 16'd0, 0, none});
      rows_tbl.push_back('{16'd24, 16'd14, 0, none});
      rows_tbl.push_back('{16'hFFF0, 16'd30, 0, none});
      rows_tbl.push_back('{16'd16, 16'd27, 0, none});
      foreach (rows_tbl[i]) begin
         row = rows_tbl[i];
         send_request(row.px, row.py, row.known, row.res);
      end
      drain();

      // Every layout, including undefined ones, at half-way points and tie cases.
      for (int lay = 0; lay < 8; lay++) begin
         write_reg(CSR_LAYOUT, 16'(lay));
         send_request(16'd0, 16'd0, 0, none);
         send_request(16'd24, 16'd0, 0, none);
         send_request(16'd0, 16'd28, 0, none);
         if (lay >= 5) send_request(16'd5, 16'd5, 1, none);
         drain();
      end

      // Zero cell size, empty map and maximal register values.
      write_reg(CSR_LAYOUT, LAYOUT_ODD_R);
      write_reg(CSR_SIZE, 16'd0);
      send_request(16'd1, 16'd1, 0, none);
      drain();
      write_reg(CSR_COLUMNS, 16'd0);
      send_request(16'd0, 16'd0, 1, none);
      drain();
      write_reg(CSR_COLUMNS, 16'd2047);
      write_reg(CSR_ROWS, 16'd0);
      send_request(16'd0, 16'd0, 1, none);
      drain();
      write_reg(CSR_ROWS, 16'd2047);
      write_reg(CSR_SIZE, 16'd1023);
      write_reg(CSR_CENTER_X, 16'h8000);
      write_reg(CSR_CENTER_Y, 16'h8000);
      write_reg(CSR_RADIUS, 16'd511);
      send_request(16'h7FFF, 16'h7FFF, 0, none);
      drain();

      // Random phases, most positions near the centre so cells land on the map.
      for (int phase = 0; phase < 22; phase++) begin
         random_config();
         spread = (size_reg == 0 ? 1 : size_reg) * 24;
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(0, 4) == 0)
               send_request(16'($urandom), 16'($urandom), 0, none);
            else
               send_request(16'(cx_reg + $signed($urandom_range(0, 2 * spread)) - spread),
                            16'(cy_reg + $signed($urandom_range(0, 2 * spread)) - spread),
                            0, none);
         end
         drain();
      end

      if (!failed && expected_cells.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
